// File: hw/rtl/leb_pkg.sv
// leb_pkg: shared types and constants for the line edit buffer.
// Holds the command codes, the sequencer states and the result struct.
// No dependencies.
package leb_pkg;

  localparam int unsigned TextSizeDef = 256;
  localparam int unsigned CharW       = 8;
  localparam int unsigned OpW         = 4;

  // Edit commands
  typedef enum logic [OpW-1:0] {
    OP_HEAD  = 4'd0,
    OP_TAIL  = 4'd1,
    OP_BACK  = 4'd2,
    OP_FWD   = 4'd3,
    OP_DEL   = 4'd4,
    OP_BS    = 4'd5,
    OP_INS   = 4'd6,
    OP_KILL  = 4'd7,
    OP_CLR   = 4'd8,
    OP_TRN   = 4'd9,
    OP_READ  = 4'd10
  } op_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_FLUSH,
    ST_INS_WR,
    ST_TR_A,
    ST_TR_B,
    ST_TR_C,
    ST_TR_D,
    ST_RD_WAIT,
    ST_DONE
  } state_e;

  // Result of one command, already cut to port widths
  typedef struct packed {
    logic [CharW-1:0] cursor_pos;
    logic [CharW-1:0] text_length;
    logic [CharW-1:0] read_char;
  } res_t;

endpackage

// File: hw/rtl/leb_ram.sv
// leb_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module leb_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/leb_ctrl.sv
// leb_ctrl: command sequencer with cursor/length registers and one shared
// address stepper that drives the character store. Depends on leb_pkg.
module leb_ctrl import leb_pkg::*; #(
  parameter int unsigned TEXT_SIZE = TextSizeDef,
  localparam int unsigned AW       = $clog2(TEXT_SIZE)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command side
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  logic [OpW-1:0]   op_i,
  input  logic [CharW-1:0] ch_i,
  input  logic [CharW-1:0] idx_i,
  // result side
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output res_t             res_o,
  // store port
  output logic             ram_we_o,
  output logic [AW-1:0]    ram_waddr_o,
  output logic [CharW-1:0] ram_wdata_o,
  output logic             ram_re_o,
  output logic [AW-1:0]    ram_raddr_o,
  input  logic [CharW-1:0] ram_rdata_i
);

  localparam int unsigned OW = (AW > CharW) ? AW : CharW;
  localparam logic [AW-1:0] MaxChars = AW'(TEXT_SIZE - 1);

  state_e state_q, state_d;
  logic [AW-1:0]    cur_q, cur_d;
  logic [AW-1:0]    len_q, len_d;
  logic [AW-1:0]    ptr_q, ptr_d;
  logic [AW-1:0]    wa_q, wa_d;
  logic [AW-1:0]    stop_q, stop_d;
  logic             up_q, up_d;
  logic             pend_q, pend_d;
  logic [CharW-1:0] ch_q, ch_d;
  logic [CharW-1:0] tmp_q, tmp_d;
  logic [CharW-1:0] rd_q, rd_d;

  // shared address stepper
  logic          step_up;
  logic [AW-1:0] step_sum;

  logic [AW-1:0] del_pos, len_m1, ins_top, tr_c1, tr_c2;
  logic [OW-1:0] idx_w, len_w, cur_w, lenr_w;

  assign step_sum = step_up ? ptr_q + AW'(1) : ptr_q - AW'(1);

  // command-time helpers
  assign len_m1  = len_q - AW'(1);
  assign del_pos = (op_e'(op_i) == OP_BS) ? cur_q - AW'(1) : cur_q;
  assign ins_top = (len_q != MaxChars) ? len_q : MaxChars - AW'(1);
  assign tr_c1   = (cur_q == '0) ? AW'(1) : cur_q;
  assign tr_c2   = (tr_c1 != len_q) ? tr_c1 + AW'(1) : tr_c1;
  assign idx_w   = OW'(idx_i);
  assign len_w   = OW'(len_q);

  // result fields, low byte of cursor and length
  assign cur_w  = OW'(cur_q);
  assign lenr_w = OW'(len_q);
  assign res_o.cursor_pos  = cur_w[CharW-1:0];
  assign res_o.text_length = lenr_w[CharW-1:0];
  assign res_o.read_char   = rd_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      len_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    wa_q   <= wa_d;
    stop_q <= stop_d;
    up_q   <= up_d;
    ch_q   <= ch_d;
    tmp_q  <= tmp_d;
    rd_q   <= rd_d;
  end

  // next state and store control
  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    len_d       = len_q;
    ptr_d       = ptr_q;
    wa_d        = wa_q;
    stop_d      = stop_q;
    up_d        = up_q;
    pend_d      = pend_q;
    ch_d        = ch_q;
    tmp_d       = tmp_q;
    rd_d        = rd_q;
    step_up     = 1'b1;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = wa_q;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = step_sum;

    unique case (state_q)
      ST_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          rd_d    = '0;
          pend_d  = 1'b0;
          state_d = ST_DONE;
          unique case (op_e'(op_i))
            OP_HEAD: cur_d = '0;
            OP_TAIL: cur_d = len_q;
            OP_BACK: begin
              if (cur_q != '0) cur_d = cur_q - AW'(1);
            end
            OP_FWD: begin
              if (cur_q < len_q) cur_d = cur_q + AW'(1);
            end
            OP_DEL, OP_BS: begin
              // backspace is a step back then a delete
              if ((op_e'(op_i) == OP_DEL && cur_q < len_q) ||
                  (op_e'(op_i) == OP_BS && cur_q != '0)) begin
                cur_d = del_pos;
                len_d = len_m1;
                if (del_pos != len_m1) begin
                  ptr_d   = del_pos;
                  up_d    = 1'b1;
                  stop_d  = len_m1;
                  state_d = ST_SHIFT;
                end
              end
            end
            OP_INS: begin
              // zero char and a cursor at the limit are refused
              if (ch_i != '0 && cur_q != MaxChars) begin
                cur_d  = cur_q + AW'(1);
                ch_d   = ch_i;
                stop_d = cur_q;
                if (len_q != MaxChars) len_d = len_q + AW'(1);
                if (ins_top != cur_q) begin
                  ptr_d   = ins_top;
                  up_d    = 1'b0;
                  state_d = ST_SHIFT;
                end else begin
                  state_d = ST_INS_WR;
                end
              end
            end
            OP_KILL: len_d = cur_q;
            OP_CLR: begin
              cur_d = '0;
              len_d = '0;
            end
            OP_TRN: begin
              if (len_q > AW'(1)) begin
                cur_d   = tr_c2;
                ptr_d   = tr_c2 - AW'(2);
                state_d = ST_TR_A;
              end
            end
            OP_READ: begin
              if (idx_w < len_w) begin
                ram_re_o    = 1'b1;
                ram_raddr_o = idx_w[AW-1:0];
                state_d     = ST_RD_WAIT;
              end
            end
            default: ;
          endcase
        end
      end

      // stream one character per cycle: read ahead, write one behind
      ST_SHIFT: begin
        step_up  = up_q;
        ram_re_o = 1'b1;
        ptr_d    = step_sum;
        wa_d     = ptr_q;
        pend_d   = 1'b1;
        ram_we_o = pend_q;
        if (step_sum == stop_q) state_d = ST_FLUSH;
      end

      ST_FLUSH: begin
        ram_we_o = 1'b1;
        state_d  = up_q ? ST_DONE : ST_INS_WR;
      end

      ST_INS_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = stop_q;
        ram_wdata_o = ch_q;
        state_d     = ST_DONE;
      end

      // transpose: read both, then write them crossed
      ST_TR_A: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = ptr_q;
        ptr_d       = step_sum;
        state_d     = ST_TR_B;
      end

      ST_TR_B: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = ptr_q;
        tmp_d       = ram_rdata_i;
        state_d     = ST_TR_C;
      end

      ST_TR_C: begin
        step_up     = 1'b0;
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q;
        ram_wdata_o = tmp_q;
        tmp_d       = ram_rdata_i;
        ptr_d       = step_sum;
        state_d     = ST_TR_D;
      end

      ST_TR_D: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = ptr_q;
        ram_wdata_o = tmp_q;
        state_d     = ST_DONE;
      end

      ST_RD_WAIT: begin
        rd_d    = ram_rdata_i;
        state_d = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/line_edit_buffer_top.sv
// line_edit_buffer_top: single-line text buffer with cursor, one edit command
// per item. Depends on leb_pkg, leb_ctrl and leb_ram.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------------
//  in      | to block  | in_valid_i / in_ready_o  | op_i, in_char_i, read_index_i
//  out     | from block| out_valid_o / out_ready_i| cursor_pos_o, text_length_o, read_char_o
//
// Cursor moves, kill, clear, unused codes and refused edits go straight to
// done; read waits on the store, and an insert with nothing to move writes
// its character at once. Transpose reads two characters, then writes them
// crossed. Delete and backspace that move characters stream the tail through
// the store one character a cycle; insert streams the other way, then writes
// the new character. The longest item is an insert at the head of a full line.
// Reset empties the buffer at once (no clearing pass); store contents stay.
// A held result in the output register does not block the next item; the
// sequencer waits in its done state only if that register is still full.
module line_edit_buffer_top import leb_pkg::*; #(
  parameter int unsigned TEXT_SIZE = TextSizeDef,
  localparam int unsigned AW       = $clog2(TEXT_SIZE)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   op_i,
  input  logic [CharW-1:0] in_char_i,
  input  logic [CharW-1:0] read_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CharW-1:0] cursor_pos_o,
  output logic [CharW-1:0] text_length_o,
  output logic [CharW-1:0] read_char_o
);

  logic             res_valid, res_ready;
  res_t             res;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [CharW-1:0] ram_wdata, ram_rdata;
  logic             out_valid_q;
  res_t             out_q;

  leb_ctrl #(
    .TEXT_SIZE (TEXT_SIZE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (in_valid_i),
    .cmd_ready_o (in_ready_o),
    .op_i        (op_i),
    .ch_i        (in_char_i),
    .idx_i       (read_index_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  leb_ram #(
    .Width (CharW),
    .Depth (TEXT_SIZE)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign cursor_pos_o  = out_q.cursor_pos;
  assign text_length_o = out_q.text_length;
  assign read_char_o   = out_q.read_char;

  // an accepted command always leaves the idle state
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("sequencer still ready after accepting an item");

  // a handed-over result shows up on the output
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res_ready |=> out_valid_o)
    else $error("result lost between sequencer and output register");

  // cursor never passes the end of the text
  a_cursor_in_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (TEXT_SIZE > 256) || (cursor_pos_o <= text_length_o))
    else $error("cursor beyond text length");

  // no store write while waiting for a command
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ram_we)
    else $error("store written while idle");

endmodule
